// ----- rtl/core/tmm_pkg.sv -----
// Shared types, widths and codes for the temperature median/mean block.
`timescale 1ns / 1ps

package tmm_pkg;

  // Sample store size and derived widths
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int TEMP_W    = 13;
  localparam int HOUR_W    = 5;
  localparam int SCALE_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = TEMP_W + ADDR_W;
  localparam int BIT_W     = $clog2(TEMP_W);
  localparam int STEP_W    = $clog2(SUM_W);

  // Celsius to Fahrenheit: num = 9*C + 32*16*5, then /5 rounded half away
  localparam int NUM_W       = 17;
  localparam int X_W         = 16;
  localparam int Q_W         = 14;
  localparam int FAHR_OFFSET = 2560;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 18;
  localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

  localparam logic [HOUR_W-1:0]  HOUR_MAX = 5'd23;
  localparam logic [SCALE_W-1:0] SCALE_C  = 8'd99;
  localparam logic [SCALE_W-1:0] SCALE_F  = 8'd102;

  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam temp_t TEMP_MAX       = 13'sd4095;
  localparam temp_t TEMP_MIN       = -13'sd4096;
  localparam temp_t LOW_LIMIT_RST  = -13'sd704;
  localparam temp_t HIGH_LIMIT_RST = 13'sd1728;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HOUR  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SCALE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STATS     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CONV,
    S_STORE,
    S_SCAN,
    S_DIV,
    S_RESP
  } tmm_state_t;

endpackage

// ----- rtl/core/temperature_median_mean.sv -----
// Top level: checks temperature readings, keeps the set, reports median and mean.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready): one reading per request (hour, temperature,
//   scale, last). in_ready is high only while the sequencer is idle.
// - Output channel (out_valid/out_ready): exactly one result per reading, held
//   in an output register until taken. The next reading is taken while a result
//   still waits; that reading then parks in the response state until the output
//   register frees up.
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
//   high; index 0 writes low_limit, index 1 writes high_limit. Write only when idle.
// Sequence
// - Error reading: S_CHECK, then S_RESP. Accepted, not last: S_CHECK, S_CONV,
//   S_STORE, S_RESP. Last reading of a set: S_STORE, S_SCAN, S_DIV, S_RESP.
//   The median is found by a 13-pass bitwise search over the store; each pass
//   reads every stored sample once through the single RAM read port. The mean
//   then comes from a 21-step restoring divider, one quotient bit per cycle.
// - in_ready returns the cycle after the result is loaded, so a new request waits
//   until the previous reading is through, plus any wait on the output register.
// Reset clears the set (count and running sum) and restores the default limits;
// the sample store itself is not cleared, only entries of the current set are read.
// A stalled receiver holds the result; the block waits in its response state.
module temperature_median_mean (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tmm_pkg::HOUR_W-1:0]       hour,
  input  tmm_pkg::temp_t                   temperature,
  input  logic [tmm_pkg::SCALE_W-1:0]      scale,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tmm_pkg::STATUS_W-1:0]     status,
  output tmm_pkg::temp_t                   median,
  output tmm_pkg::temp_t                   mean,
  output logic [tmm_pkg::CNT_W-1:0]        sample_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  tmm_pkg::temp_t                   cfg_data
);

  import tmm_pkg::*;

  tmm_state_t state, state_next;

  // Configuration and set state
  temp_t                    low_limit, high_limit;
  logic [CNT_W-1:0]         stored_count;
  logic signed [SUM_W-1:0]  running_sum;

  // Captured request
  logic [HOUR_W-1:0]        hour_q;
  temp_t                    temp_q;
  logic [SCALE_W-1:0]       scale_q;
  logic                     last_q;

  // Conversion pipeline
  logic [X_W-1:0]           conv_x;
  logic                     conv_neg;
  logic                     is_celsius;
  temp_t                    val_q;

  // Staged result, loaded into the output register in S_RESP
  logic [STATUS_W-1:0]      resp_status;
  temp_t                    resp_median;
  temp_t                    resp_mean;
  logic [CNT_W-1:0]         resp_count;

  // Shared sequencer registers
  logic [STEP_W-1:0]        step;
  logic [CNT_W-1:0]         idx;
  logic                     pend;
  logic [CNT_W-1:0]         le_cnt;
  logic [TEMP_W-1:0]        med_r;
  logic [CNT_W-1:0]         rem;
  logic [SUM_W-1:0]         quo;
  logic                     sum_neg;

  // Control
  logic                     in_fire;
  logic                     ram_we;
  logic                     load_out;

  // ---------------------------------------------------------------------
  // Reading checks, in priority order: hour, raw range, scale, store full
  // ---------------------------------------------------------------------
  logic [STATUS_W-1:0] chk_status;

  always_comb begin
    if (hour_q > HOUR_MAX) begin
      chk_status = ST_BAD_HOUR;
    end else if (temp_q < low_limit || temp_q > high_limit) begin
      chk_status = ST_RANGE;
    end else if (scale_q != SCALE_C && scale_q != SCALE_F) begin
      chk_status = ST_BAD_SCALE;
    end else if (stored_count >= CNT_W'(CAPACITY)) begin
      chk_status = ST_OVERFLOW;
    end else begin
      chk_status = ST_ACCEPTED;
    end
  end

  // 9*C + offset, then magnitude + 2 for round half away from zero
  logic signed [NUM_W-1:0] t_ext, num, num_abs;

  assign t_ext   = NUM_W'(temp_q);
  assign num     = (t_ext <<< 3) + t_ext + NUM_W'(FAHR_OFFSET);
  assign num_abs = num[NUM_W-1] ? -num : num;

  // Divide by 5 through the reciprocal, then saturate to the 13-bit range
  logic [X_W+RECIP_W-1:0] prod;
  logic [Q_W-1:0]         q_mag;
  temp_t                  conv_val;

  assign prod  = conv_x * RECIP_5;
  assign q_mag = prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

  always_comb begin
    if (conv_neg) begin
      conv_val = (q_mag > Q_W'(-int'(TEMP_MIN))) ? TEMP_MIN : -temp_t'(q_mag[TEMP_W-1:0]);
    end else begin
      conv_val = (q_mag > Q_W'(TEMP_MAX)) ? TEMP_MAX : temp_t'(q_mag[TEMP_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Sample store
  // ---------------------------------------------------------------------
  logic [TEMP_W-1:0] rd_data;
  logic              issue;

  assign issue = (idx < stored_count);

  tmm_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_count[ADDR_W-1:0]),
    .wdata (val_q),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------
  // Median search: offset-binary values, one result bit per pass.
  // Bit b stays 0 when more than count/2 samples are <= prefix with bit b
  // clear and all lower bits set.
  // ---------------------------------------------------------------------
  logic [TEMP_W-1:0] trial;
  logic [TEMP_W-1:0] rd_u;
  logic              pass_done;
  logic              bit_zero;

  assign trial     = med_r | ((TEMP_W'(1) << step[BIT_W-1:0]) - TEMP_W'(1));
  assign rd_u      = {~rd_data[TEMP_W-1], rd_data[TEMP_W-2:0]};
  assign pass_done = !issue && !pend;
  assign bit_zero  = le_cnt > (stored_count >> 1);

  // ---------------------------------------------------------------------
  // Restoring divider step for the mean
  // ---------------------------------------------------------------------
  logic [CNT_W:0]    rem_try;
  logic              div_ge;
  logic [CNT_W-1:0]  rem_next;
  logic [SUM_W-1:0]  quo_next;
  temp_t             mean_fin;

  assign rem_try  = {rem, quo[SUM_W-1]};
  assign div_ge   = rem_try >= (CNT_W+1)'(stored_count);
  assign rem_next = div_ge ? CNT_W'(rem_try - (CNT_W+1)'(stored_count)) : CNT_W'(rem_try);
  assign quo_next = {quo[SUM_W-2:0], div_ge};
  assign mean_fin = sum_neg ? -temp_t'(quo_next[TEMP_W-1:0]) : temp_t'(quo_next[TEMP_W-1:0]);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (chk_status == ST_ACCEPTED) ? S_CONV : S_RESP;
      end
      S_CONV: begin
        state_next = S_STORE;
      end
      S_STORE: begin
        state_next = last_q ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (pass_done && step == '0) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == '0) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: control outputs
  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_STORE: ram_we   = 1'b1;
      S_RESP:  load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      low_limit    <= LOW_LIMIT_RST;
      high_limit   <= HIGH_LIMIT_RST;
      stored_count <= '0;
      running_sum  <= '0;
    end else begin
      state <= state_next;

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOW_LIMIT:  low_limit  <= cfg_data;
          REG_HIGH_LIMIT: high_limit <= cfg_data;
          default: ;
        endcase
      end

      // Any error or overflow discards the set
      if (state == S_CHECK && chk_status != ST_ACCEPTED) begin
        stored_count <= '0;
        running_sum  <= '0;
      end else if (state == S_STORE) begin
        stored_count <= stored_count + CNT_W'(1);
        running_sum  <= running_sum + SUM_W'(val_q);
      end else if (state == S_DIV && step == '0) begin
        stored_count <= '0;
        running_sum  <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hour_q  <= hour;
      temp_q  <= temperature;
      scale_q <= scale;
      last_q  <= last;
    end

    case (state)
      S_CHECK: begin
        conv_x      <= X_W'(num_abs) + X_W'(2);
        conv_neg    <= num[NUM_W-1];
        is_celsius  <= (scale_q == SCALE_C);
        resp_status <= chk_status;
        resp_median <= '0;
        resp_mean   <= '0;
        resp_count  <= '0;
      end
      S_CONV: begin
        val_q <= is_celsius ? conv_val : temp_q;
      end
      S_STORE: begin
        resp_status <= ST_ACCEPTED;
        resp_count  <= stored_count + CNT_W'(1);
        step        <= STEP_W'(TEMP_W - 1);
        idx         <= '0;
        pend        <= 1'b0;
        le_cnt      <= '0;
        med_r       <= '0;
      end
      S_SCAN: begin
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
        pend <= issue;
        if (pend) begin
          le_cnt <= le_cnt + CNT_W'(rd_u <= trial);
        end
        if (pass_done) begin
          if (!bit_zero) begin
            med_r[step[BIT_W-1:0]] <= 1'b1;
          end
          idx    <= '0;
          le_cnt <= '0;
          if (step == '0) begin
            // Set up the divider on the magnitude of the sum
            step    <= STEP_W'(SUM_W - 1);
            rem     <= '0;
            quo     <= running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
            sum_neg <= running_sum[SUM_W-1];
          end else begin
            step <= step - STEP_W'(1);
          end
        end
      end
      S_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        if (step == '0) begin
          resp_status <= ST_STATS;
          resp_median <= {~med_r[TEMP_W-1], med_r[TEMP_W-2:0]};
          resp_mean   <= mean_fin;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
      default: ;
    endcase

    if (load_out) begin
      status       <= resp_status;
      median       <= resp_median;
      mean         <= resp_mean;
      sample_count <= resp_count;
    end
  end

endmodule

// ----- rtl/core/tmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/temperature_median_mean_test.sv -----
// Self-checking testbench for temperature_median_mean: random sets, limits and handshake gaps.
`timescale 1ns / 1ps

module temperature_median_mean_test;
  import tmm_pkg::*;

  // No request or response for this many cycles means the block is stuck.
  // Worst correct case is a full 256-sample set closing.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [HOUR_W-1:0]  hr;
    temp_t              temp;
    logic [SCALE_W-1:0] scl;
    logic               fin;
  } reading_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    temp_t               median;
    temp_t               mean;
    logic [CNT_W-1:0]    count;
  } sensor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [HOUR_W-1:0]    hour = '0;
  temp_t                temperature = '0;
  logic [SCALE_W-1:0]   scale = '0;
  logic                 last = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  temp_t                median;
  temp_t                mean;
  logic [CNT_W-1:0]     sample_count;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_LIMIT;
  temp_t                cfg_data = '0;

  temperature_median_mean dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hour         (hour),
    .temperature  (temperature),
    .scale        (scale),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .median       (median),
    .mean         (mean),
    .sample_count (sample_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Readings waiting to be offered, and results owed by the block (oldest first)
  reading_t       pending[$];
  sensor_result_t owed_results[$];

  // Shadow of the block: limits plus the set being collected, in 1/16 F
  temp_t  lim_lo = LOW_LIMIT_RST;
  temp_t  lim_hi = HIGH_LIMIT_RST;
  temp_t  kept[CAPACITY];
  int     n_kept = 0;
  longint kept_sum = 0;

  int fault_count = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  task automatic flag_fault(input string msg);
    $display("MISMATCH @%0t result #%0d: %s", $realtime, results_seen, msg);
    fault_count++;
  endtask

  // Work out the response to one reading and advance the shadow set.
  function automatic sensor_result_t score_reading(input reading_t r);
    sensor_result_t res;
    temp_t fahr;
    int num, q, v, j;
    int ordered[CAPACITY];
    res.status = ST_ACCEPTED;
    res.median = '0;
    res.mean   = '0;
    res.count  = '0;
    // check order matters: hour, then raw range, then scale, then room
    if (r.hr > HOUR_MAX) res.status = ST_BAD_HOUR;
    else if (r.temp < lim_lo || r.temp > lim_hi) res.status = ST_RANGE;
    else if (r.scl != SCALE_C && r.scl != SCALE_F) res.status = ST_BAD_SCALE;
    else if (n_kept >= CAPACITY) res.status = ST_OVERFLOW;
    if (res.status != ST_ACCEPTED) begin
      // any failure throws the whole set away
      n_kept = 0;
      kept_sum = 0;
      return res;
    end
    if (r.scl == SCALE_C) begin
      // F*16 = (9*C*16 + 32*16*5) / 5, rounded half away from zero, then clamped
      num = int'(r.temp) * 9 + FAHR_OFFSET;
      q = (num >= 0) ? (num + 2) / 5 : -((2 - num) / 5);
      if (q > TEMP_MAX) q = TEMP_MAX;
      else if (q < TEMP_MIN) q = TEMP_MIN;
      fahr = temp_t'(q);
    end else begin
      fahr = r.temp;
    end
    kept[n_kept] = fahr;
    n_kept++;
    kept_sum += fahr;
    res.count = CNT_W'(n_kept);
    if (r.fin) begin
      // insertion sort, then pick index n/2 (upper median)
      for (int i = 0; i < n_kept; i++) begin
        v = kept[i];
        j = i;
        while (j > 0 && ordered[j-1] > v) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = v;
      end
      res.status = ST_STATS;
      res.median = temp_t'(ordered[n_kept/2]);
      res.mean   = temp_t'(kept_sum / n_kept);  // signed divide truncates toward zero
      n_kept = 0;
      kept_sum = 0;
    end
    return res;
  endfunction

  // Driver: offers queued readings, with a random gap between requests and
  // occasional back-to-back stretches. The shadow model advances on each
  // accepted request.
  reading_t shown;
  int gap_left = 0;
  int drv_calm = 0;

  always @(posedge clk) begin : drive_readings
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        owed_results = {owed_results, score_reading(shown)};
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          shown = pending.pop_front();
          hour        <= shown.hr;
          temperature <= shown.temp;
          scale       <= shown.scl;
          last        <= shown.fin;
          offer = 1'b1;
          if (drv_calm > 0) begin
            drv_calm--;
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0) drv_calm = 40;
          end
        end
      end
      // single update per edge: valid stays high across back-to-back requests
      in_valid <= offer;
    end
  end

  // Monitor: takes results, checks each against the oldest owed result, and
  // drops ready for a random gap after a taken result, outside calm stretches.
  int stall_left = 0;
  int mon_calm = 0;

  always @(posedge clk) begin : check_results
    sensor_result_t want;
    logic take;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          flag_fault($sformatf("unexpected result, status %0d", status));
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status)
            flag_fault($sformatf("status %0d, want %0d", status, want.status));
          if (median !== want.median)
            flag_fault($sformatf("median %0d, want %0d", median, want.median));
          if (mean !== want.mean)
            flag_fault($sformatf("mean %0d, want %0d", mean, want.mean));
          if (sample_count !== want.count)
            flag_fault($sformatf("sample_count %0d, want %0d", sample_count, want.count));
        end
        if (mon_calm > 0) begin
          mon_calm--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 3);
          if ($urandom_range(0, 31) == 0) mon_calm = 40;
        end
      end
      take = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end
      out_ready <= take;
    end
  end

  // Watchdog: any request, response or register write counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_reading(input logic [HOUR_W-1:0] h, input temp_t t,
                               input logic [SCALE_W-1:0] s, input logic l);
    pending = {pending, reading_t'{h, t, s, l}};
  endtask

  // Well-formed reading inside the current limits (any temp if inverted); edges of the window often
  task automatic queue_good(input logic fin);
    temp_t t;
    int pick;
    pick = $urandom_range(0, 7);
    if (lim_lo > lim_hi) t = temp_t'($urandom);
    else if (pick == 0) t = lim_lo;
    else if (pick == 1) t = lim_hi;
    else t = temp_t'(int'(lim_lo) + int'($urandom_range(int'(lim_hi) - int'(lim_lo))));
    queue_reading(HOUR_W'($urandom_range(0, 23)), t,
                  $urandom_range(0, 1) ? SCALE_C : SCALE_F, fin);
  endtask

  // Anything goes: any hour, any byte, temps just past the limits now and then
  task automatic queue_noise();
    temp_t t;
    logic [SCALE_W-1:0] s;
    case ($urandom_range(0, 3))
      0: t = lim_lo - 13'sd1;
      1: t = lim_hi + 13'sd1;
      default: t = temp_t'($urandom);
    endcase
    case ($urandom_range(0, 2))
      0: s = SCALE_C;
      1: s = SCALE_F;
      default: s = SCALE_W'($urandom_range(0, 255));
    endcase
    queue_reading(HOUR_W'($urandom_range(0, 31)), t, s, 1'($urandom_range(0, 1)));
  endtask

  // Mostly short sets closed by a last mark, some longer, ~10% junk mixed in
  task automatic queue_random_sets(input int total);
    int made, len;
    made = 0;
    while (made < total) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_good(i == len - 1);
      end
      made += len;
    end
  endtask

  // Fill the store completely; either close it on the 256th reading or push
  // one more good reading to hit the overflow path.
  task automatic queue_full_set(input logic close_it);
    queue_reading(HOUR_MAX + 5'd1, '0, SCALE_F, 1'b0);  // bad hour: start from empty
    for (int i = 0; i < CAPACITY; i++) queue_good(close_it && i == CAPACITY - 1);
    if (!close_it) queue_good(1'($urandom_range(0, 1)));
  endtask

  // Block is idle once nothing is queued, offered or owed. Checked on the
  // falling edge so the driver's updates for this cycle have landed.
  task automatic wait_idle();
    do @(negedge clk); while (pending.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Both limit registers, back to back; shadow copy follows each write
  task automatic set_limits(input temp_t lo, input temp_t hi);
    cfg_index <= REG_LOW_LIMIT;
    cfg_data  <= lo;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lim_lo = lo;
    cfg_index <= REG_HIGH_LIMIT;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    lim_hi = hi;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    temp_t lo;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset limits (-704..1728)
    queue_reading(HOUR_MAX, -13'sd704, SCALE_F, 1'b0);   // hour and low limit at edge
    queue_reading(5'd0, 13'sd1728, SCALE_C, 1'b0);       // high limit, Celsius
    queue_reading(5'd12, -13'sd300, SCALE_C, 1'b0);      // negative numerator rounding
    queue_reading(5'd7, 13'sd0, SCALE_C, 1'b1);          // even count, upper median
    queue_reading(5'd5, 13'sd100, SCALE_C, 1'b1);        // one-sample set
    queue_reading(5'd24, 13'sd0, SCALE_F, 1'b0);         // first bad hour
    queue_reading(5'd31, 13'sd4095, 8'd0, 1'b1);         // hour wins over range and scale
    queue_reading(5'd1, -13'sd705, 8'hFF, 1'b0);         // range wins over scale
    queue_reading(5'd1, 13'sd1729, SCALE_F, 1'b0);
    queue_reading(5'd2, 13'sd50, 8'd0, 1'b0);            // bad scale bytes
    queue_reading(5'd2, 13'sd50, 8'hFF, 1'b0);
    queue_reading(5'd2, 13'sd50, 8'd101, 1'b1);          // error carrying the last mark
    queue_reading(5'd3, 13'sd10, SCALE_F, 1'b0);
    queue_reading(5'd4, 13'sd20, SCALE_F, 1'b0);
    queue_reading(5'd4, 13'sd20, 8'd98, 1'b1);           // set dropped at its end
    queue_reading(5'd6, -13'sd3, SCALE_F, 1'b0);
    queue_reading(5'd6, -13'sd2, SCALE_F, 1'b1);         // mean -2.5 truncates to -2
    queue_reading(5'd9, -13'sd704, SCALE_C, 1'b1);       // negative conversion
    wait_idle();

    // Full-range limits: conversion clamps at both ends
    set_limits(TEMP_MIN, TEMP_MAX);
    queue_reading(5'd10, TEMP_MAX, SCALE_C, 1'b0);
    queue_reading(5'd11, TEMP_MIN, SCALE_C, 1'b0);
    queue_reading(5'd12, TEMP_MAX, SCALE_F, 1'b0);
    queue_reading(5'd13, TEMP_MIN, SCALE_F, 1'b1);
    queue_random_sets(200);
    wait_idle();

    // Inverted window: everything past the hour check is out of range
    set_limits(13'sd100, -13'sd100);
    queue_random_sets(30);
    wait_idle();

    // Random narrow window
    lo = temp_t'(-2000 + int'($urandom_range(0, 3000)));
    set_limits(lo, temp_t'(int'(lo) + int'($urandom_range(0, 600))));
    queue_random_sets(150);
    wait_idle();

    // Store at capacity: one full set closed, one pushed past the top
    set_limits(TEMP_MIN, TEMP_MAX);
    queue_full_set(1'b1);
    queue_full_set(1'b0);
    queue_random_sets(60);
    wait_idle();

    // Single-value windows at both ends of the range
    set_limits(TEMP_MAX, TEMP_MAX);
    queue_random_sets(30);
    wait_idle();
    set_limits(TEMP_MIN, TEMP_MIN);
    queue_random_sets(30);
    wait_idle();

    // Back to the power-on window
    set_limits(LOW_LIMIT_RST, HIGH_LIMIT_RST);
    queue_random_sets(60);
    wait_idle();

    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tmm_pkg.sv
rtl/core/tmm_ram.sv
rtl/core/temperature_median_mean.sv
tb/temperature_median_mean_test.sv
